FILE: hw/rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam int unsigned WinDepth  = 4;
   localparam int unsigned FillWidth = $clog2(WinDepth + 1);
   localparam int unsigned CpWidth   = 21;

   localparam logic [15:0]        REPLACEMENT = 16'hFFFD;
   localparam logic [15:0]        HI_SURR     = 16'hD800;
   localparam logic [15:0]        LO_SURR     = 16'hDC00;
   localparam logic [CpWidth-1:0] SUPP_BASE   = 21'h010000;
   localparam logic [CpWidth-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [15:0]        TERM_UNIT   = 16'h0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOW,
      ST_TERM,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic low;
      logic term;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic dec_ok;
      logic is_pair;
      logic fin;
      logic pend_vld;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/u8u16_ctrl.sv
// Controller state machine that sequences byte loads, decodes and result flushes.
module u8u16_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8u16_pkg::dp_status_type status,
   output u8u16_pkg::dp_cmd_type    cmd
);

   u8u16_pkg::state_type state_ff;
   u8u16_pkg::state_type state_in;
   logic                 can_push;

   assign can_push = !status.pend_vld || status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8u16_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         u8u16_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = u8u16_pkg::ST_SCAN;
            end
         end
         u8u16_pkg::ST_SCAN: begin
            if (status.dec_ok) begin
               if (can_push) begin
                  state_in = status.is_pair ? u8u16_pkg::ST_LOW : u8u16_pkg::ST_SCAN;
               end
            end else begin
               state_in = status.fin ? u8u16_pkg::ST_TERM : u8u16_pkg::ST_FLUSH;
            end
         end
         u8u16_pkg::ST_LOW: begin
            if (can_push) begin
               state_in = u8u16_pkg::ST_SCAN;
            end
         end
         u8u16_pkg::ST_TERM: begin
            if (can_push) begin
               state_in = u8u16_pkg::ST_FLUSH;
            end
         end
         u8u16_pkg::ST_FLUSH: begin
            if (can_push) begin
               state_in = u8u16_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = u8u16_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         u8u16_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         u8u16_pkg::ST_SCAN: begin
            cmd.step = status.dec_ok && can_push;
         end
         u8u16_pkg::ST_LOW: begin
            cmd.low = can_push;
         end
         u8u16_pkg::ST_TERM: begin
            cmd.term = can_push;
         end
         u8u16_pkg::ST_FLUSH: begin
            cmd.flush = can_push;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/u8u16_dp.sv
// Datapath: byte window, sequence decoder, surrogate split, pending unit and output register.
module u8u16_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_final_byte,
   input  u8u16_pkg::dp_cmd_type    cmd,
   output u8u16_pkg::dp_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              rsp_code_unit,
   output logic                     rsp_is_terminator,
   output logic                     rsp_run_end
);

   localparam int unsigned CW = u8u16_pkg::CpWidth;
   localparam int unsigned FW = u8u16_pkg::FillWidth;
   localparam int unsigned WD = u8u16_pkg::WinDepth;

   logic [7:0]    win_ff [WD];
   logic [7:0]    win_in [WD];
   logic [FW-1:0] fill_ff, fill_in;
   logic          fin_ff;

   logic [15:0]   pend_unit_ff;
   logic          pend_term_ff;
   logic          pend_vld_ff, pend_vld_in;
   logic [15:0]   low_unit_ff;

   logic          out_vld_ff;
   logic [15:0]   out_unit_ff;
   logic          out_term_ff;
   logic          out_end_ff;

   logic [1:0]    extra;
   logic          bad_lead;
   logic          complete;
   logic          dec_ok;
   logic          c1ok, c2ok, c3ok;
   logic [CW-1:0] cp;
   logic [FW-1:0] used;
   logic          is_pair;
   logic [19:0]   supp_off;
   logic [15:0]   hi_unit, lo_unit;
   logic          push;
   logic          out_free;

   // lead class
   always_comb begin
      extra    = 2'd0;
      bad_lead = 1'b0;
      if (win_ff[0][7] == 1'b0) begin
         extra = 2'd0;
      end else if (win_ff[0][7:5] == 3'b110) begin
         extra = 2'd1;
      end else if (win_ff[0][7:4] == 4'b1110) begin
         extra = 2'd2;
      end else if (win_ff[0][7:3] == 5'b11110) begin
         extra = 2'd3;
      end else begin
         bad_lead = 1'b1;
      end
   end

   assign complete = fill_ff >= (FW'(extra) + FW'(1));
   assign dec_ok   = (fill_ff != '0) && (complete || fin_ff);
   assign c1ok     = win_ff[1][7:6] == 2'b10;
   assign c2ok     = win_ff[2][7:6] == 2'b10;
   assign c3ok     = win_ff[3][7:6] == 2'b10;

   always_comb begin
      cp   = CW'(u8u16_pkg::REPLACEMENT);
      used = FW'(1);
      if (complete) begin
         case (extra)
            2'd0: begin
               if (!bad_lead) begin
                  cp = CW'(win_ff[0]);
               end
            end
            2'd1: begin
               if (c1ok) begin
                  cp   = CW'({win_ff[0][4:0], win_ff[1][5:0]});
                  used = FW'(2);
               end
            end
            2'd2: begin
               if (!c1ok) begin
                  used = FW'(1);
               end else if (!c2ok) begin
                  used = FW'(2);
               end else begin
                  cp   = CW'({win_ff[0][3:0], win_ff[1][5:0], win_ff[2][5:0]});
                  used = FW'(3);
               end
            end
            default: begin
               if (!c1ok) begin
                  used = FW'(1);
               end else if (!c2ok) begin
                  used = FW'(2);
               end else if (!c3ok) begin
                  used = FW'(3);
               end else begin
                  cp   = {win_ff[0][2:0], win_ff[1][5:0], win_ff[2][5:0], win_ff[3][5:0]};
                  used = FW'(4);
               end
            end
         endcase
      end
   end

   assign is_pair  = (cp >= u8u16_pkg::SUPP_BASE) && (cp <= u8u16_pkg::CP_MAX);
   assign supp_off = 20'(cp - u8u16_pkg::SUPP_BASE);
   assign hi_unit  = is_pair ? (u8u16_pkg::HI_SURR + 16'(supp_off[19:10])) : cp[15:0];
   assign lo_unit  = u8u16_pkg::LO_SURR + 16'(supp_off[9:0]);

   // window update: load at fill, drop the consumed front bytes, or empty on terminator
   always_comb begin
      logic [1:0] src;
      for (int i = 0; i < WD; i++) begin
         win_in[i] = win_ff[i];
      end
      fill_in = fill_ff;
      src     = 2'd0;
      if (cmd.load) begin
         if (fill_ff < FW'(WD)) begin
            win_in[fill_ff[1:0]] = req_data_byte;
            fill_in              = fill_ff + FW'(1);
         end
      end else if (cmd.step) begin
         for (int i = 0; i < WD; i++) begin
            src = 2'(i) + used[1:0];
            if (i + int'(used) < WD) begin
               win_in[i] = win_ff[src];
            end
         end
         fill_in = fill_ff - used;
      end else if (cmd.term) begin
         fill_in = '0;
      end
   end

   assign out_free = !out_vld_ff || rsp_ready;
   assign push     = pend_vld_ff && (cmd.step || cmd.low || cmd.term || cmd.flush);

   always_comb begin
      pend_vld_in = pend_vld_ff;
      if (cmd.step || cmd.low || cmd.term) begin
         pend_vld_in = 1'b1;
      end else if (cmd.flush) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         pend_vld_ff <= pend_vld_in;
         if (push) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WD; i++) begin
         win_ff[i] <= win_in[i];
      end
      if (cmd.load) begin
         fin_ff <= req_final_byte;
      end
      if (cmd.step) begin
         pend_unit_ff <= hi_unit;
         pend_term_ff <= 1'b0;
         low_unit_ff  <= lo_unit;
      end else if (cmd.low) begin
         pend_unit_ff <= low_unit_ff;
         pend_term_ff <= 1'b0;
      end else if (cmd.term) begin
         pend_unit_ff <= u8u16_pkg::TERM_UNIT;
         pend_term_ff <= 1'b1;
      end
      if (push) begin
         out_unit_ff <= pend_unit_ff;
         out_term_ff <= pend_term_ff;
         out_end_ff  <= cmd.flush;
      end
   end

   assign status.dec_ok   = dec_ok;
   assign status.is_pair  = is_pair;
   assign status.fin      = fin_ff;
   assign status.pend_vld = pend_vld_ff;
   assign status.out_free = out_free;

   assign rsp_valid         = out_vld_ff;
   assign rsp_code_unit     = out_unit_ff;
   assign rsp_is_terminator = out_term_ff;
   assign rsp_run_end       = out_end_ff;

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// Each accepted byte starts a run that yields its code units (the terminator
// on a final byte included); each unit passes through the pending unit register
// and then the output register, and every step stalls while a unit is pending
// and the output register is not taken. Units come from the shared sequence
// decoder, the low surrogate and terminator steps; each byte waits for the previous run.
// Reset (synchronous, active high) empties the byte window and the result path.
module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_is_terminator,
   output logic        rsp_run_end
);

   u8u16_pkg::dp_cmd_type    cmd;
   u8u16_pkg::dp_status_type status;

   u8u16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   u8u16_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .req_final_byte    (req_final_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

FILE: hw/rtl/u8u16_checker.sv
// Port-level checker for the transcoder and its bind to the top level.
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_is_terminator,
   input logic        rsp_run_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit))
      else $error("result item changed while stalled");

   a_term_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_code_unit == 16'h0000 && rsp_run_end)
      else $error("terminator item malformed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while one is in work");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_code_unit     (rsp_code_unit),
   .rsp_is_terminator (rsp_is_terminator),
   .rsp_run_end       (rsp_run_end)
);
